// File: rtl/core/sas_pkg.sv
// Shared constants, codes and interface types for the spectrum align-and-sum block.
`timescale 1ns / 1ps

package sas_pkg;

    localparam int DEPTH = 4096;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int MZ_W  = 32;
    localparam int INT_W = 32;
    localparam int TOL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;
    localparam int RIDX_W = 12;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(13107);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_LOWER   = 3'd1;
    localparam logic [ST_W-1:0] ST_UPPER   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOMATCH = 3'd3;
    localparam logic [ST_W-1:0] ST_PASTEND = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd5;
    localparam logic [ST_W-1:0] ST_BADIDX  = 3'd6;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             mz_we;
        logic             int_we;
        logic [IDX_W-1:0] wr_addr;
        logic [MZ_W-1:0]  wr_mz;
        logic [INT_W-1:0] wr_int;
    } store_req_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [RIDX_W-1:0] idx;
        logic [MZ_W-1:0]   mz;
        logic [INT_W-1:0]  inten;
        logic [CNT_W-1:0]  count;
    } result_t;

endpackage

// File: rtl/core/sas_store.sv
// Reference spectrum storage: m/z and intensity memories, one write and one read port.
`timescale 1ns / 1ps

module sas_store (
    input  logic                         clk,
    input  sas_pkg::store_req_t          st_req,
    output logic [sas_pkg::MZ_W-1:0]     rd_mz,
    output logic [sas_pkg::INT_W-1:0]    rd_int
);
    import sas_pkg::*;

    logic [MZ_W-1:0]  mz_mem  [DEPTH];
    logic [INT_W-1:0] int_mem [DEPTH];
    logic [MZ_W-1:0]  rd_mz_reg;
    logic [INT_W-1:0] rd_int_reg;

    always_ff @(posedge clk)
    begin
        if (st_req.mz_we)
        begin
            mz_mem[st_req.wr_addr] <= st_req.wr_mz;
        end
        if (st_req.rd_en)
        begin
            rd_mz_reg <= mz_mem[st_req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_req.int_we)
        begin
            int_mem[st_req.wr_addr] <= st_req.wr_int;
        end
        if (st_req.rd_en)
        begin
            rd_int_reg <= int_mem[st_req.rd_addr];
        end
    end

    assign rd_mz  = rd_mz_reg;
    assign rd_int = rd_int_reg;

endmodule

// File: rtl/core/sas_engine.sv
// Request sequencer: append, clear, read-back and cursor scan with read-modify-write.
`timescale 1ns / 1ps

module sas_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [sas_pkg::OP_W-1:0]      op,
    input  logic [sas_pkg::MZ_W-1:0]      mz,
    input  logic [sas_pkg::INT_W-1:0]     intensity,
    input  logic                          first_of_scan,
    input  logic [sas_pkg::RIDX_W-1:0]    read_index,
    input  logic [sas_pkg::TOL_W-1:0]     tolerance,
    output sas_pkg::store_req_t           st_req,
    input  logic [sas_pkg::MZ_W-1:0]      rd_mz,
    input  logic [sas_pkg::INT_W-1:0]     rd_int,
    output logic                          res_valid,
    input  logic                          res_ready,
    output sas_pkg::result_t              res
);
    import sas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_LO_CHK,
        S_DECIDE,
        S_READ_WAIT,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic             past_end_reg, past_end_next;
    logic [MZ_W-1:0]  mz_reg, mz_next;
    logic [INT_W-1:0] inten_reg, inten_next;
    logic [RIDX_W-1:0] ridx_reg, ridx_next;
    logic [MZ_W-1:0]  hi_mz_reg, hi_mz_next;
    logic [INT_W-1:0] hi_int_reg, hi_int_next;
    logic [MZ_W-1:0]  lo_mz_reg, lo_mz_next;
    logic [INT_W-1:0] lo_int_reg, lo_int_next;
    logic [MZ_W-1:0]  right_reg, right_next;
    logic [MZ_W-1:0]  left_reg, left_next;
    result_t          res_reg, res_next;

    logic [CNT_W-1:0] cursor_dec;
    logic [MZ_W-1:0]  rd_dist;
    logic [INT_W:0]   lo_sum;
    logic [INT_W:0]   hi_sum;
    logic [INT_W-1:0] lo_sat;
    logic [INT_W-1:0] hi_sat;

    assign cursor_dec = cursor_reg - CNT_W'(1);
    assign rd_dist    = (rd_mz > mz_reg) ? (rd_mz - mz_reg) : (mz_reg - rd_mz);
    assign lo_sum     = {1'b0, lo_int_reg} + {1'b0, inten_reg};
    assign hi_sum     = {1'b0, hi_int_reg} + {1'b0, inten_reg};
    assign lo_sat     = lo_sum[INT_W] ? '1 : lo_sum[INT_W-1:0];
    assign hi_sat     = hi_sum[INT_W] ? '1 : hi_sum[INT_W-1:0];

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        past_end_next = past_end_reg;
        mz_next       = mz_reg;
        inten_next    = inten_reg;
        ridx_next     = ridx_reg;
        hi_mz_next    = hi_mz_reg;
        hi_int_next   = hi_int_reg;
        lo_mz_next    = lo_mz_reg;
        lo_int_next   = lo_int_reg;
        right_next    = right_reg;
        left_next     = left_reg;
        res_next      = res_reg;

        st_req         = '0;
        st_req.wr_addr = count_reg[IDX_W-1:0];
        st_req.wr_mz   = mz;
        st_req.wr_int  = intensity;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mz_next    = mz;
                    inten_next = intensity;
                    ridx_next  = read_index;
                    case (op)
                        OP_CLEAR:
                        begin
                            count_next    = '0;
                            cursor_next   = '0;
                            past_end_next = 1'b0;
                            res_next      = '{ST_DONE, '0, '0, '0, '0};
                            state_next    = S_DONE;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                res_next = '{ST_FULL, '0, '0, '0, count_reg};
                            end
                            else
                            begin
                                st_req.mz_we  = 1'b1;
                                st_req.int_we = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                res_next      = '{ST_DONE, RIDX_W'(count_reg), mz, intensity,
                                                  count_reg + CNT_W'(1)};
                            end
                            state_next = S_DONE;
                        end
                        OP_ADD:
                        begin
                            if (first_of_scan)
                            begin
                                cursor_next   = '0;
                                past_end_next = 1'b0;
                            end
                            state_next = S_SCAN;
                        end
                        OP_READ:
                        begin
                            if (CNT_W'(read_index) >= count_reg)
                            begin
                                res_next   = '{ST_BADIDX, read_index, '0, '0, count_reg};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                st_req.rd_en   = 1'b1;
                                st_req.rd_addr = IDX_W'(read_index);
                                state_next     = S_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // bound check comes before any store read
                if (past_end_reg || cursor_reg >= count_reg)
                begin
                    past_end_next = 1'b1;
                    res_next      = '{ST_PASTEND, '0, '0, '0, count_reg};
                    state_next    = S_DONE;
                end
                else
                begin
                    st_req.rd_en   = 1'b1;
                    st_req.rd_addr = cursor_reg[IDX_W-1:0];
                    state_next     = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (rd_mz < mz_reg)
                begin
                    cursor_next = cursor_reg + CNT_W'(1);
                    state_next  = S_SCAN;
                end
                else
                begin
                    hi_mz_next  = rd_mz;
                    hi_int_next = rd_int;
                    right_next  = rd_dist;
                    if (cursor_reg != '0)
                    begin
                        st_req.rd_en   = 1'b1;
                        st_req.rd_addr = cursor_dec[IDX_W-1:0];
                        state_next     = S_LO_CHK;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_LO_CHK:
            begin
                lo_mz_next  = rd_mz;
                lo_int_next = rd_int;
                left_next   = rd_dist;
                state_next  = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (cursor_reg != '0 && left_reg < right_reg && left_reg < tolerance)
                begin
                    st_req.int_we  = 1'b1;
                    st_req.wr_addr = cursor_dec[IDX_W-1:0];
                    st_req.wr_int  = lo_sat;
                    res_next       = '{ST_LOWER, RIDX_W'(cursor_dec), lo_mz_reg, lo_sat,
                                       count_reg};
                end
                else if (right_reg < tolerance)
                begin
                    st_req.int_we  = 1'b1;
                    st_req.wr_addr = cursor_reg[IDX_W-1:0];
                    st_req.wr_int  = hi_sat;
                    res_next       = '{ST_UPPER, RIDX_W'(cursor_reg), hi_mz_reg, hi_sat,
                                       count_reg};
                end
                else
                begin
                    res_next = '{ST_NOMATCH, RIDX_W'(cursor_reg), hi_mz_reg, hi_int_reg,
                                 count_reg};
                end
                state_next = S_DONE;
            end

            S_READ_WAIT:
            begin
                res_next   = '{ST_DONE, ridx_reg, rd_mz, rd_int, count_reg};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            past_end_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            past_end_reg <= past_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mz_reg     <= mz_next;
        inten_reg  <= inten_next;
        ridx_reg   <= ridx_next;
        hi_mz_reg  <= hi_mz_next;
        hi_int_reg <= hi_int_next;
        lo_mz_reg  <= lo_mz_next;
        lo_int_reg <= lo_int_next;
        right_reg  <= right_next;
        left_reg   <= left_next;
        res_reg    <= res_next;
    end

endmodule

// File: rtl/core/spectrum_align_and_sum_top.sv
// Top level: tolerance register, sequencer, reference store and response register.
//
//   channel    direction  handshake             payload
//   request    in         req_valid/req_ready   op, mz, intensity, first_of_scan, read_index
//   response   out        rsp_valid/rsp_ready   status, entry_index, entry_mz,
//                                               entry_intensity, stored_count
//   config     in         mz_tolerance_we       mz_tolerance_wdata
//
// One request at a time. Clear, append and bad-index read need no store read; read-back
// does one memory read. Add reads nothing once the scan is past the end, else reads the
// entry at the cursor, and the lower neighbor too when the cursor is above entry zero;
// each stored point the cursor skips takes one more read on the single store read port.
// The response register lets the next request in while a response waits.
// Reset clears counts and flags and loads TOL_RESET; the store needs no clearing pass.
`timescale 1ns / 1ps

module spectrum_align_and_sum_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mz_tolerance_we,
    input  logic [sas_pkg::TOL_W-1:0]     mz_tolerance_wdata,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [sas_pkg::OP_W-1:0]      op,
    input  logic [sas_pkg::MZ_W-1:0]      mz,
    input  logic [sas_pkg::INT_W-1:0]     intensity,
    input  logic                          first_of_scan,
    input  logic [sas_pkg::RIDX_W-1:0]    read_index,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [sas_pkg::ST_W-1:0]      status,
    output logic [sas_pkg::RIDX_W-1:0]    entry_index,
    output logic [sas_pkg::MZ_W-1:0]      entry_mz,
    output logic [sas_pkg::INT_W-1:0]     entry_intensity,
    output logic [sas_pkg::CNT_W-1:0]     stored_count
);
    import sas_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    result_t          rsp_reg;
    store_req_t       st_req;
    logic [MZ_W-1:0]  rd_mz;
    logic [INT_W-1:0] rd_int;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (mz_tolerance_we)
        begin
            tol_reg <= mz_tolerance_wdata;
        end
    end

    sas_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .op            (op),
        .mz            (mz),
        .intensity     (intensity),
        .first_of_scan (first_of_scan),
        .read_index    (read_index),
        .tolerance     (tol_reg),
        .st_req        (st_req),
        .rd_mz         (rd_mz),
        .rd_int        (rd_int),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    sas_store u_store (
        .clk    (clk),
        .st_req (st_req),
        .rd_mz  (rd_mz),
        .rd_int (rd_int)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = rsp_reg.status;
    assign entry_index     = rsp_reg.idx;
    assign entry_mz        = rsp_reg.mz;
    assign entry_intensity = rsp_reg.inten;
    assign stored_count    = rsp_reg.count;

endmodule
